@@ rtl/ssrp_pkg.sv @@
// Shared types and constants for the servo slew-rate positioner.
`timescale 1ns / 1ps

package ssrp_pkg;

	// Field widths
	localparam int ANGLE_W = 8;
	localparam int SPEED_W = 12;
	localparam int CMD_W   = 2;

	// Parameter defaults
	localparam int INTERVAL_BITS_DEF   = 12;
	localparam int SPEED_FRAC_BITS_DEF = 4;

	// Physical constants behind the step interval
	localparam int MS_PER_S    = 1000;
	localparam int S_PER_MIN   = 60;
	localparam int DEG_PER_REV = 360;
	localparam int SPEED_MUL   = DEG_PER_REV / S_PER_MIN;

	// Register file
	localparam int ADDR_W    = 4;
	localparam int REG_IDX_W = 2;
	localparam int DATA_W    = 32;

	localparam logic [REG_IDX_W-1:0] REG_POS_MIN  = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_POS_MAX  = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_POS_INIT = 2'd2;

	localparam logic [ANGLE_W-1:0] POS_MIN_RST  = 8'd0;
	localparam logic [ANGLE_W-1:0] POS_MAX_RST  = 8'd180;
	localparam logic [ANGLE_W-1:0] POS_INIT_RST = 8'd0;

	typedef enum logic [CMD_W-1:0] {
		CMD_TICK = 2'd0,
		CMD_JUMP = 2'd1,
		CMD_SLEW = 2'd2
	} cmd_t;

endpackage

@@ rtl/ssrp_div.sv @@
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module ssrp_div #(
	parameter int NUM_W = 14,
	parameter int DEN_W = 15
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] dividend,
	input  logic [DEN_W-1:0] divisor,
	output logic             done,
	output logic [NUM_W-1:0] quotient
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] num_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             done_q;

	logic [DEN_W:0]   part;
	logic             ge;
	logic [DEN_W:0]   diff;

	assign part = {rem_q, num_q[NUM_W-1]};
	assign ge   = (part >= {1'b0, den_q});
	assign diff = part - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CNT_W'(NUM_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1))
					done_q <= 1'b1;
			end
		end
	end

	// datapath: remainder and shifting dividend/quotient
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			rem_q <= '0;
			den_q <= divisor;
		end else if (cnt_q != '0) begin
			num_q <= {num_q[NUM_W-2:0], ge};
			rem_q <= ge ? diff[DEN_W-1:0] : part[DEN_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = num_q;

endmodule

@@ rtl/servo_slew_rate_positioner.sv @@
// Servo slew-rate positioner: keeps an angle and steps it toward a goal on 1 ms ticks.
// Tick, jump, unused commands and speed-zero slews: idle goes straight to the update state,
// which registers the result and holds while the result slot is full; then back to idle.
// Slew: idle, then the divider state, then the update state; the restoring divider gives
// one quotient bit a cycle. No new item is taken until the block is back in idle.
// Reset (arst_n low, asynchronous): registers to defaults, angle/goal = pos_init.
`timescale 1ns / 1ps

module servo_slew_rate_positioner #(
	parameter int INTERVAL_BITS   = ssrp_pkg::INTERVAL_BITS_DEF,
	parameter int SPEED_FRAC_BITS = ssrp_pkg::SPEED_FRAC_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// APB-style register port
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [ssrp_pkg::ADDR_W-1:0]       paddr,
	input  logic [ssrp_pkg::DATA_W-1:0]       pwdata,
	output logic [ssrp_pkg::DATA_W-1:0]       prdata,
	output logic                              pready,
	// command channel
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [ssrp_pkg::CMD_W-1:0]        cmd,
	input  logic [ssrp_pkg::ANGLE_W-1:0]      target_angle,
	input  logic [ssrp_pkg::SPEED_W-1:0]      speed,
	// result channel
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [ssrp_pkg::ANGLE_W-1:0]      angle,
	output logic                              moving,
	output logic                              stepped
);

	localparam int AW    = ssrp_pkg::ANGLE_W;
	localparam int IB    = INTERVAL_BITS;
	// dividend is MS_PER_S scaled by the speed fraction, divisor is 6 * speed
	localparam int NUM_W = $clog2(ssrp_pkg::MS_PER_S + 1) + SPEED_FRAC_BITS;
	localparam int DEN_W = ssrp_pkg::SPEED_W + $clog2(ssrp_pkg::SPEED_MUL + 1);
	localparam int SAT_W = (NUM_W > IB) ? NUM_W : IB;
	localparam logic [NUM_W-1:0] DIVIDEND =
		NUM_W'(ssrp_pkg::MS_PER_S * (2 ** SPEED_FRAC_BITS));

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_FIN
	} state_t;

	state_t state_q;

	// configuration
	logic [AW-1:0] pos_min_q, pos_max_q, pos_init_q;

	// servo state
	logic [AW-1:0] cur_q, goal_q;
	logic          slewing_q, down_q;
	logic [IB-1:0] interval_q, elapsed_q;

	// held command
	ssrp_pkg::cmd_t              cmd_q;
	logic [AW-1:0]               target_q;
	logic [ssrp_pkg::SPEED_W-1:0] speed_q;

	// output register
	logic          out_valid_q, moving_q, stepped_q;
	logic [AW-1:0] angle_q;

	logic                       in_xfer, cfg_wr;
	logic [ssrp_pkg::REG_IDX_W-1:0] reg_idx;
	logic                       div_start, div_done;
	logic [DEN_W-1:0]           divisor;
	logic [NUM_W-1:0]           quot;

	// next-state terms for the update cycle
	logic [AW-1:0] tgt_c, cur_nxt, goal_nxt;
	logic          slew_nxt, down_nxt, stepped_nxt;
	logic [IB-1:0] el_inc, el_nxt, iv_nxt, quot_iv;
	logic [SAT_W-1:0] quot_ext;
	logic          out_free;

	assign in_xfer  = in_valid && in_ready;
	assign in_ready = (state_q == ST_IDLE);
	assign cfg_wr   = psel && penable && pwrite && pready;
	assign reg_idx  = paddr[ssrp_pkg::ADDR_W-1:ssrp_pkg::ADDR_W-ssrp_pkg::REG_IDX_W];
	assign pready   = 1'b1;
	assign out_free = !out_valid_q || out_ready;

	// slews with a non-zero speed go through the divider
	assign div_start = in_xfer && (cmd == ssrp_pkg::CMD_SLEW) && (speed != '0);
	assign divisor   = DEN_W'(speed) * DEN_W'(ssrp_pkg::SPEED_MUL);

	ssrp_div #(
		.NUM_W (NUM_W),
		.DEN_W (DEN_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (DIVIDEND),
		.divisor  (divisor),
		.done     (div_done),
		.quotient (quot)
	);

	// register read-back
	always_comb begin
		case (reg_idx)
			ssrp_pkg::REG_POS_MIN:  prdata = ssrp_pkg::DATA_W'(pos_min_q);
			ssrp_pkg::REG_POS_MAX:  prdata = ssrp_pkg::DATA_W'(pos_max_q);
			ssrp_pkg::REG_POS_INIT: prdata = ssrp_pkg::DATA_W'(pos_init_q);
			default:                prdata = '0;
		endcase
	end

	// clamp: floor test wins when the limits cross
	assign tgt_c = (target_q <= pos_min_q) ? pos_min_q :
	               (target_q >= pos_max_q) ? pos_max_q : target_q;

	// saturating quotient -> interval
	assign quot_ext = SAT_W'(quot);
	assign quot_iv  = (quot_ext > SAT_W'({IB{1'b1}})) ? {IB{1'b1}} : quot_ext[IB-1:0];

	assign el_inc = (elapsed_q == {IB{1'b1}}) ? elapsed_q : elapsed_q + 1'b1;

	always_comb begin
		cur_nxt     = cur_q;
		goal_nxt    = goal_q;
		slew_nxt    = slewing_q;
		down_nxt    = down_q;
		iv_nxt      = interval_q;
		el_nxt      = elapsed_q;
		stepped_nxt = 1'b0;
		case (cmd_q)
			ssrp_pkg::CMD_TICK: begin
				el_nxt = el_inc;
				if (slewing_q && (el_inc >= interval_q)) begin
					cur_nxt     = down_q ? cur_q - 1'b1 : cur_q + 1'b1;
					stepped_nxt = 1'b1;
					el_nxt      = '0;
					slew_nxt    = (cur_nxt != goal_q);
				end
			end
			ssrp_pkg::CMD_JUMP: begin
				stepped_nxt = (cur_q != tgt_c);
				cur_nxt     = tgt_c;
				goal_nxt    = tgt_c;
				slew_nxt    = 1'b0;
			end
			ssrp_pkg::CMD_SLEW: begin
				goal_nxt = tgt_c;
				down_nxt = (tgt_c < cur_q);
				iv_nxt   = (speed_q == '0) ? {IB{1'b1}} : quot_iv;
				slew_nxt = (tgt_c != cur_q);
			end
			default: ; // unused code: no change, no time passes
		endcase
	end

	// held command fields (payload, no reset)
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			cmd_q    <= ssrp_pkg::cmd_t'(cmd);
			target_q <= target_angle;
			speed_q  <= speed;
		end
	end

	// sequencer, servo state, registers and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pos_min_q   <= ssrp_pkg::POS_MIN_RST;
			pos_max_q   <= ssrp_pkg::POS_MAX_RST;
			pos_init_q  <= ssrp_pkg::POS_INIT_RST;
			cur_q       <= ssrp_pkg::POS_INIT_RST;
			goal_q      <= ssrp_pkg::POS_INIT_RST;
			slewing_q   <= 1'b0;
			down_q      <= 1'b0;
			interval_q  <= '0;
			elapsed_q   <= '0;
			out_valid_q <= 1'b0;
			angle_q     <= '0;
			moving_q    <= 1'b0;
			stepped_q   <= 1'b0;
		end else begin
			if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;

			// register writes must arrive only while idle; the block itself does not enforce this
			if (cfg_wr) begin
				case (reg_idx)
					ssrp_pkg::REG_POS_MIN:  pos_min_q <= pwdata[AW-1:0];
					ssrp_pkg::REG_POS_MAX:  pos_max_q <= pwdata[AW-1:0];
					ssrp_pkg::REG_POS_INIT: begin
						pos_init_q <= pwdata[AW-1:0];
						cur_q      <= pwdata[AW-1:0];
						goal_q     <= pwdata[AW-1:0];
						slewing_q  <= 1'b0;
					end
					default: ;
				endcase
			end

			case (state_q)
				ST_IDLE: begin
					if (in_xfer)
						state_q <= div_start ? ST_DIV : ST_FIN;
				end
				ST_DIV: begin
					if (div_done)
						state_q <= ST_FIN;
				end
				ST_FIN: begin
					// commit only once the result slot can take the transfer
					if (out_free) begin
						cur_q       <= cur_nxt;
						goal_q      <= goal_nxt;
						slewing_q   <= slew_nxt;
						down_q      <= down_nxt;
						interval_q  <= iv_nxt;
						elapsed_q   <= el_nxt;
						angle_q     <= cur_nxt;
						moving_q    <= slew_nxt;
						stepped_q   <= stepped_nxt;
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign angle     = angle_q;
	assign moving    = moving_q;
	assign stepped   = stepped_q;

endmodule

@@ rtl/ssrp_check.sv @@
// Port-level checks for the servo slew-rate positioner, bound to the top level.
`timescale 1ns / 1ps

module ssrp_check (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          psel,
	input logic                          penable,
	input logic                          pwrite,
	input logic [ssrp_pkg::ADDR_W-1:0]   paddr,
	input logic [ssrp_pkg::DATA_W-1:0]   pwdata,
	input logic [ssrp_pkg::DATA_W-1:0]   prdata,
	input logic                          pready,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic [ssrp_pkg::CMD_W-1:0]    cmd,
	input logic [ssrp_pkg::ANGLE_W-1:0]  target_angle,
	input logic [ssrp_pkg::SPEED_W-1:0]  speed,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [ssrp_pkg::ANGLE_W-1:0]  angle,
	input logic                          moving,
	input logic                          stepped
);

	// one item at a time: busy straight after a transfer
	a_busy_after_xfer: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("in_ready high the cycle after a transfer");

	// non-slew commands with a free result slot finish in the update cycle
	a_fast_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !out_valid && (cmd != ssrp_pkg::CMD_SLEW)
		|=> ##1 out_valid)
		else $error("tick/jump result late");

	// a jump always ends motion
	a_jump_stops: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !out_valid && (cmd == ssrp_pkg::CMD_JUMP)
		|=> ##1 (out_valid && !moving))
		else $error("moving set after a jump");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(angle) && $stable(moving)
		&& $stable(stepped))
		else $error("stalled result changed");

endmodule

bind servo_slew_rate_positioner ssrp_check u_ssrp_check (.*);

@@ test/tb_top.sv @@
// Self-checking testbench for the servo slew-rate positioner.
`timescale 1ns / 1ps

module tb_top;

	// cmd code that the block must pass through untouched
	localparam logic [ssrp_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
	localparam int IV_W = ssrp_pkg::INTERVAL_BITS_DEF;
	localparam logic [IV_W-1:0] IV_MAX = '1;

	// idle margin after the last result before a register write or the end,
	// comfortably past any trailing work
	localparam int SETTLE_CYCLES = 24;
	// slowest sane run is ~1800 transfers
	localparam int CYCLE_LIMIT   = 400_000;
	localparam int RANDOM_ITEMS  = 1680;
	localparam int NUM_PHASES    = 8;

	typedef struct packed {
		logic [ssrp_pkg::ANGLE_W-1:0] angle;
		logic                         moving;
		logic                         stepped;
	} angle_report_t;

	// Tracks the servo state from accepted commands and checks each result
	// transfer against the oldest outstanding prediction.
	class angle_tracker;
		logic [ssrp_pkg::ANGLE_W-1:0] lo, hi, init_pos;
		logic [ssrp_pkg::ANGLE_W-1:0] cur, goal;
		bit                           slewing, down;
		logic [IV_W-1:0]              period, elapsed;
		angle_report_t                due_reports[$];
		int                           errors;

		function new();
			lo       = ssrp_pkg::POS_MIN_RST;
			hi       = ssrp_pkg::POS_MAX_RST;
			init_pos = ssrp_pkg::POS_INIT_RST;
			cur      = ssrp_pkg::POS_INIT_RST;
			goal     = ssrp_pkg::POS_INIT_RST;
			slewing  = 1'b0;
			down     = 1'b0;
			period   = '0;
			elapsed  = '0;
			errors   = 0;
		endfunction

		function logic [ssrp_pkg::ANGLE_W-1:0] clamp_angle(
				logic [ssrp_pkg::ANGLE_W-1:0] t);
			if (t <= lo)
				return lo;
			if (t >= hi)
				return hi;
			return t;
		endfunction

		// ms per degree: (1000 << frac) / (6 * speed), saturating
		function logic [IV_W-1:0] step_period(logic [ssrp_pkg::SPEED_W-1:0] s);
			longint unsigned q;
			if (s == '0)
				return IV_MAX;
			q = (longint'(ssrp_pkg::MS_PER_S) << ssrp_pkg::SPEED_FRAC_BITS_DEF)
				/ (ssrp_pkg::SPEED_MUL * longint'(s));
			return (q > IV_MAX) ? IV_MAX : q[IV_W-1:0];
		endfunction

		function void apply_write(logic [ssrp_pkg::REG_IDX_W-1:0] idx,
				logic [ssrp_pkg::DATA_W-1:0] v);
			case (idx)
				ssrp_pkg::REG_POS_MIN: lo = v[ssrp_pkg::ANGLE_W-1:0];
				ssrp_pkg::REG_POS_MAX: hi = v[ssrp_pkg::ANGLE_W-1:0];
				ssrp_pkg::REG_POS_INIT: begin
					init_pos = v[ssrp_pkg::ANGLE_W-1:0];
					cur      = v[ssrp_pkg::ANGLE_W-1:0];
					goal     = v[ssrp_pkg::ANGLE_W-1:0];
					slewing  = 1'b0;
				end
				default: ;
			endcase
		endfunction

		function void note_command(logic [ssrp_pkg::CMD_W-1:0] c,
				logic [ssrp_pkg::ANGLE_W-1:0] t, logic [ssrp_pkg::SPEED_W-1:0] s);
			logic [ssrp_pkg::ANGLE_W-1:0] tgt;
			bit                           moved;
			tgt   = clamp_angle(t);
			moved = 1'b0;
			case (c)
				ssrp_pkg::CMD_TICK: begin
					if (elapsed != IV_MAX)
						elapsed++;
					if (slewing && elapsed >= period) begin
						cur     = down ? cur - 1'b1 : cur + 1'b1;
						moved   = 1'b1;
						elapsed = '0;
						if (cur == goal)
							slewing = 1'b0;
					end
				end
				ssrp_pkg::CMD_JUMP: begin
					moved   = (cur != tgt);
					cur     = tgt;
					goal    = tgt;
					slewing = 1'b0;
				end
				ssrp_pkg::CMD_SLEW: begin
					goal    = tgt;
					down    = (tgt < cur);
					period  = step_period(s);
					slewing = (tgt != cur);
				end
				default: ;
			endcase
			due_reports.push_back('{cur, slewing, moved});
		endfunction

		function void check_report(logic [ssrp_pkg::ANGLE_W-1:0] a, logic mv, logic st);
			angle_report_t want;
			if (due_reports.size() == 0) begin
				$display("%0t: unexpected result angle=%0d moving=%0d stepped=%0d",
					$time, a, mv, st);
				errors++;
				return;
			end
			want = due_reports.pop_front();
			if (a !== want.angle) begin
				$display("%0t: angle expected %0d actual %0d", $time, want.angle, a);
				errors++;
			end
			if (mv !== want.moving) begin
				$display("%0t: moving expected %0d actual %0d", $time, want.moving, mv);
				errors++;
			end
			if (st !== want.stepped) begin
				$display("%0t: stepped expected %0d actual %0d", $time, want.stepped, st);
				errors++;
			end
		endfunction

		function int outstanding();
			return due_reports.size();
		endfunction
	endclass

	logic                           clk = 1'b0;
	logic                           arst_n;
	logic                           psel, penable, pwrite;
	logic [ssrp_pkg::ADDR_W-1:0]    paddr;
	logic [ssrp_pkg::DATA_W-1:0]    pwdata;
	logic [ssrp_pkg::DATA_W-1:0]    prdata;
	logic                           pready;
	logic                           in_valid, in_ready;
	logic [ssrp_pkg::CMD_W-1:0]     cmd;
	logic [ssrp_pkg::ANGLE_W-1:0]   target_angle;
	logic [ssrp_pkg::SPEED_W-1:0]   speed;
	logic                           out_valid, out_ready;
	logic [ssrp_pkg::ANGLE_W-1:0]   angle;
	logic                           moving, stepped;

	angle_tracker tracker = new();

	int items_sent  = 0;
	int burst_left  = 0;
	int cycle_count = 0;
	int stall_mode  = 0;
	int stall_left  = 0;
	int stall_phase = 0;

	servo_slew_rate_positioner dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 0;
	end

	// Monitor: everything is sampled at the rising edge, before this edge's
	// updates land, so register writes, command and result transfers are
	// seen in the order the block saw them.
	always @(posedge clk) begin
		if (arst_n) begin
			if (psel && penable && pwrite && pready)
				tracker.apply_write(paddr[ssrp_pkg::ADDR_W-1:2], pwdata);
			if (in_valid && in_ready)
				tracker.note_command(cmd, target_angle, speed);
			if (out_valid && out_ready)
				tracker.check_report(angle, moving, stepped);
		end
	end

	// Watchdog on total run length
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("servo_slew_rate_positioner verification failed");
			$finish;
		end
	end

	// Result side back-pressure: a new random mode for each random-length run, from
	// wide open through coin-toss and a fixed duty pattern to mostly stalled.
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode  = $urandom_range(0, 3);
			stall_left  = $urandom_range(20, 300);
			stall_phase = 0;
		end
		stall_left--;
		stall_phase++;
		case (stall_mode)
			0:       out_ready <= 1'b1;
			1:       out_ready <= ($urandom_range(0, 1) == 1);
			2:       out_ready <= ((stall_phase % 7) < 3);
			default: out_ready <= ($urandom_range(0, 7) == 0);
		endcase
	end

	// One command transfer. Commands go out in bursts of random length;
	// between bursts valid drops for a random gap (or not at all).
	task automatic send_item(logic [ssrp_pkg::CMD_W-1:0] c,
			logic [ssrp_pkg::ANGLE_W-1:0] t, logic [ssrp_pkg::SPEED_W-1:0] s);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		in_valid     <= 1'b1;
		cmd          <= c;
		target_angle <= t;
		speed        <= s;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		items_sent++;
	endtask

	task automatic send_ticks(int n);
		repeat (n)
			send_item(ssrp_pkg::CMD_TICK, 8'($urandom), 12'($urandom));
	endtask

	// APB write: setup, access, then idle, so that back-to-back
	// writes never assign psel twice in one step
	task automatic write_reg(logic [ssrp_pkg::REG_IDX_W-1:0] idx,
			logic [ssrp_pkg::ANGLE_W-1:0] v);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= {24'($urandom_range(0, 32'hFF_FFFF)), v};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	// Drop valid and wait until every predicted result has been checked
	task automatic settle();
		in_valid  <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (tracker.outstanding() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Mostly fast speeds so that slews actually step within a short tick run
	function automatic logic [ssrp_pkg::SPEED_W-1:0] pick_speed();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 12'($urandom_range(1000, 4095));
		if (r < 80)
			return 12'($urandom_range(60, 999));
		if (r < 93)
			return 12'($urandom_range(0, 4095));
		return ($urandom_range(0, 1) == 0) ? 12'd0 : 12'($urandom_range(1, 8));
	endfunction

	// Targets: anywhere, near the current angle (so slews finish), on or next to a limit, or at 0 or 255
	function automatic logic [ssrp_pkg::ANGLE_W-1:0] pick_target();
		int r;
		r = $urandom_range(0, 9);
		if (r < 4)
			return 8'($urandom_range(0, 255));
		if (r < 8)
			return 8'(tracker.cur + $urandom_range(0, 12) - 6);
		case ($urandom_range(0, 5))
			0:       return 8'd0;
			1:       return 8'd255;
			2:       return tracker.lo;
			3:       return tracker.hi;
			4:       return tracker.lo + 8'd1;
			default: return tracker.hi - 8'd1;
		endcase
	endfunction

	task automatic run_directed();
		send_item(ssrp_pkg::CMD_TICK, 8'hFF, 12'hFFF);    // idle tick, all-ones fields
		send_item(ssrp_pkg::CMD_JUMP, 8'd255, 12'd0);     // above ceiling, clamps
		send_item(ssrp_pkg::CMD_JUMP, 8'd0, 12'hFFF);     // back to floor
		send_item(ssrp_pkg::CMD_JUMP, 8'd0, 12'd5);       // jump to where it already is
		send_item(ssrp_pkg::CMD_SLEW, 8'd0, 12'd4095);    // slew to current angle: no start
		send_item(CMD_UNUSED, 8'd200, 12'd100);           // unused code, nothing moves
		send_item(ssrp_pkg::CMD_SLEW, 8'd3, 12'd4095);    // fastest slew, zero interval
		send_ticks(4);                                    // steps to goal, then stops
		send_item(ssrp_pkg::CMD_SLEW, 8'd1, 12'd2667);    // downward slew
		send_ticks(3);
		send_item(ssrp_pkg::CMD_SLEW, 8'd200, 12'd0);     // speed zero: longest interval
		send_ticks(1);
		send_item(ssrp_pkg::CMD_SLEW, 8'd170, 12'd1);     // retarget mid-slew, slowest non-zero speed
		send_item(ssrp_pkg::CMD_JUMP, 8'd90, 12'hAAA);    // jump cancels the slew
		send_item(ssrp_pkg::CMD_SLEW, 8'd90, 12'h555);    // slew to current angle again
		send_item(CMD_UNUSED, 8'h55, 12'hAAA);
		send_ticks(1);
	endtask

	task automatic run_random(int quota);
		int stop_at;
		stop_at = items_sent + quota;
		while (items_sent < stop_at) begin
			case ($urandom_range(0, 19))
				0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10: begin
					// plain slew followed by a tick run
					send_item(ssrp_pkg::CMD_SLEW, pick_target(), pick_speed());
					send_ticks($urandom_range(1, 40));
				end
				11, 12, 13: begin
					send_item(ssrp_pkg::CMD_JUMP, pick_target(), 12'($urandom));
					send_ticks($urandom_range(0, 4));
				end
				14, 15, 16: begin
					// slew cut short by a retarget or a jump
					send_item(ssrp_pkg::CMD_SLEW, pick_target(), pick_speed());
					send_ticks($urandom_range(0, 5));
					send_item(2'($urandom_range(1, 2)), pick_target(), pick_speed());
					send_ticks($urandom_range(0, 10));
				end
				default: begin
					send_item(2'($urandom_range(0, 3)), 8'($urandom), 12'($urandom));
				end
			endcase
		end
	endtask

	initial begin
		logic [ssrp_pkg::ANGLE_W-1:0] set_lo [NUM_PHASES];
		logic [ssrp_pkg::ANGLE_W-1:0] set_hi [NUM_PHASES];
		logic [ssrp_pkg::ANGLE_W-1:0] set_init [NUM_PHASES];
		// limit settings: defaults, full range, inverted, pinned, extremes, narrow, random
		set_lo   = '{8'd0,   8'd0,   8'd255, 8'd90, 8'd0, 8'd255, 8'd30,  8'd0};
		set_hi   = '{8'd180, 8'd255, 8'd0,   8'd90, 8'd0, 8'd255, 8'd150, 8'd0};
		set_init = '{8'd0,   8'd255, 8'd128, 8'd17, 8'd0, 8'd255, 8'd200, 8'd0};
		set_lo[NUM_PHASES-1]   = 8'($urandom_range(0, 255));
		set_hi[NUM_PHASES-1]   = 8'($urandom_range(0, 255));
		set_init[NUM_PHASES-1] = 8'($urandom_range(0, 255));

		arst_n       = 1'b0;
		psel         = 1'b0;
		penable      = 1'b0;
		pwrite       = 1'b0;
		paddr        = '0;
		pwdata       = '0;
		in_valid     = 1'b0;
		cmd          = ssrp_pkg::CMD_TICK;
		target_angle = '0;
		speed        = '0;
		out_ready    = 1'b0;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed();

		for (int p = 0; p < NUM_PHASES; p++) begin
			settle();
			write_reg(ssrp_pkg::REG_POS_MIN, set_lo[p]);
			write_reg(ssrp_pkg::REG_POS_MAX, set_hi[p]);
			write_reg(ssrp_pkg::REG_POS_INIT, set_init[p]);
			run_random(RANDOM_ITEMS / NUM_PHASES);
		end

		settle();
		if (tracker.outstanding() != 0) begin
			$display("%0t: %0d results never arrived", $time, tracker.outstanding());
			tracker.errors++;
		end
		if (tracker.errors == 0)
			$display("servo_slew_rate_positioner verification clean");
		else
			$display("servo_slew_rate_positioner verification failed");
		$finish;
	end

endmodule

@@ servo_slew_rate_positioner.f @@
rtl/ssrp_pkg.sv
rtl/ssrp_div.sv
rtl/servo_slew_rate_positioner.sv
rtl/ssrp_check.sv
test/tb_top.sv
